FILE: src/npc_pkg.sv
// package for the nearest palette color search block
// types, widths and constants shared by every file; no dependencies
`default_nettype none

package npc_pkg;

  localparam int PALETTE_SIZE_DEFAULT = 256;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 8;
  localparam int GAIN_W  = 16;
  localparam int ENTRY_W = 3 * COLOR_W;
  localparam int PROD_W  = COLOR_W + GAIN_W;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int BEST_W  = 24;
  localparam int MAX_DEPTH = 256;

  localparam logic [BEST_W-1:0]  INIT_BEST_DIST = BEST_W'(10000000);
  localparam logic [GAIN_W-1:0]  UNITY_GAIN     = GAIN_W'(256);
  localparam logic [COLOR_W-1:0] COMP_MAX       = COLOR_W'(255);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } dist_t;

endpackage

`default_nettype wire

FILE: src/npc_channels.sv
// handshake channels of the nearest palette color search block
// depends on npc_pkg for field widths
`default_nettype none

interface npc_item_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [npc_pkg::IDX_W-1:0]   entry_index;
  logic [npc_pkg::COLOR_W-1:0] red;
  logic [npc_pkg::COLOR_W-1:0] green;
  logic [npc_pkg::COLOR_W-1:0] blue;
  logic                        skip_zero;

  modport source (output valid, mode, entry_index, red, green, blue, skip_zero, input ready);
  modport sink   (input valid, mode, entry_index, red, green, blue, skip_zero, output ready);
endinterface

interface npc_result_if;
  logic                      valid;
  logic                      ready;
  logic [npc_pkg::IDX_W-1:0] nearest_index;

  modport source (output valid, nearest_index, input ready);
  modport sink   (input valid, nearest_index, output ready);
endinterface

interface npc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [npc_pkg::GAIN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: src/npc_palette_mem.sv
// palette memory: one write port, one registered read port
// per-entry valid bits make unwritten entries read as zero; depends on npc_pkg
`default_nettype none

module npc_palette_mem #(
  parameter int DEPTH  = npc_pkg::MAX_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [npc_pkg::ENTRY_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [npc_pkg::ENTRY_W-1:0] rdata
);

  logic [npc_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            written;
  logic [npc_pkg::ENTRY_W-1:0] rdata_raw;
  logic                        rhit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_raw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rhit    <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rhit <= written[raddr];
    end
  end

  assign rdata = rhit ? rdata_raw : '0;

endmodule

`default_nettype wire

FILE: src/npc_dist.sv
// distance pipeline: brightness scale, squared differences, sum
// three register stages; depends on npc_pkg
`default_nettype none

module npc_dist (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [npc_pkg::IDX_W-1:0]   in_idx,
  input  wire logic [npc_pkg::ENTRY_W-1:0] entry,
  input  wire logic [npc_pkg::GAIN_W-1:0]  gain,
  input  wire logic [npc_pkg::COLOR_W-1:0] q_red,
  input  wire logic [npc_pkg::COLOR_W-1:0] q_green,
  input  wire logic [npc_pkg::COLOR_W-1:0] q_blue,
  output npc_pkg::dist_t                   res,
  output logic                             busy
);

  localparam int CW = npc_pkg::COLOR_W;
  localparam int PW = npc_pkg::PROD_W;
  localparam int SW = npc_pkg::SQ_W;
  localparam int DW = npc_pkg::DIST_W;

  function automatic logic [CW-1:0] sat_scale(input logic [PW-1:0] p);
    logic [PW-CW-1:0] v;
    v = p[PW-1:CW];
    return (v > (PW-CW)'(npc_pkg::COMP_MAX)) ? npc_pkg::COMP_MAX : v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic                        v1, v2, v3;
  logic [npc_pkg::IDX_W-1:0]   idx1, idx2, idx3;
  logic [PW-1:0]               p_r, p_g, p_b;
  logic [SW-1:0]               sq_r, sq_g, sq_b;
  logic [DW-1:0]               sum;
  logic [CW-1:0]               d_r, d_g, d_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    d_r = abs_diff(sat_scale(p_r), q_red);
    d_g = abs_diff(sat_scale(p_g), q_green);
    d_b = abs_diff(sat_scale(p_b), q_blue);
  end

  always_ff @(posedge clk) begin
    idx1 <= in_idx;
    p_r  <= PW'(entry[3*CW-1:2*CW]) * PW'(gain);
    p_g  <= PW'(entry[2*CW-1:CW]) * PW'(gain);
    p_b  <= PW'(entry[CW-1:0]) * PW'(gain);
    idx2 <= idx1;
    sq_r <= SW'(d_r) * SW'(d_r);
    sq_g <= SW'(d_g) * SW'(d_g);
    sq_b <= SW'(d_b) * SW'(d_b);
    idx3 <= idx2;
    sum  <= DW'(sq_r) + DW'(sq_g) + DW'(sq_b);
  end

  assign res.valid    = v3;
  assign res.idx      = idx3;
  assign res.distance = sum;
  assign busy         = v1 | v2 | v3;

endmodule

`default_nettype wire

FILE: src/nearest_palette_color_search.sv
// top level: palette memory, scan sequencer, running minimum, output register
// depends on npc_pkg, npc_channels, npc_palette_mem and npc_dist
//
//  channel   dir  payload                                        handshake
//  items     in   mode, entry_index, red, green, blue, skip_zero  valid/ready
//  results   out  nearest_index                                   valid/ready
//  cfg       in   data (brightness_gain)                          valid/ready
//
// a write item gives no result
// a query reads one palette entry per cycle, up to min(PALETTE_SIZE,256) entries,
// through the single memory read port into the distance path
// reset clears the palette valid bits at once, gain returns to unity
// items wait while a query runs; a query's end stalls until the result register is free
`default_nettype none

module nearest_palette_color_search #(
  parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  npc_item_if.sink      items,
  npc_result_if.source  results,
  npc_cfg_if.sink       cfg
);

  localparam int DEPTH  = (PALETTE_SIZE < npc_pkg::MAX_DEPTH) ? PALETTE_SIZE
                                                               : npc_pkg::MAX_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  npc_pkg::state_t state, state_next;

  logic [npc_pkg::GAIN_W-1:0]  gain;
  logic [npc_pkg::COLOR_W-1:0] q_red, q_green, q_blue;
  logic                        q_skip;
  logic [ADDR_W-1:0]           scan_addr;
  logic                        rd_valid;
  logic [npc_pkg::IDX_W-1:0]   rd_idx;
  logic [npc_pkg::IDX_W-1:0]   best;
  logic [npc_pkg::BEST_W-1:0]  best_dist;
  logic [npc_pkg::IDX_W-1:0]   out_index;
  logic                        out_valid;

  logic                        accept, start, wr_en, issue, load, pipe_busy;
  logic [npc_pkg::ENTRY_W-1:0] rdata;
  npc_pkg::dist_t              dres;

  assign accept = items.valid && items.ready;
  assign start  = accept && (items.mode == npc_pkg::MODE_QUERY);
  assign wr_en  = accept && (items.mode == npc_pkg::MODE_WRITE)
                  && ({1'b0, items.entry_index} < 9'(DEPTH));

  npc_palette_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (wr_en),
    .waddr (items.entry_index[ADDR_W-1:0]),
    .wdata ({items.red, items.green, items.blue}),
    .raddr (scan_addr),
    .rdata (rdata)
  );

  npc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_idx   (rd_idx),
    .entry    (rdata),
    .gain     (gain),
    .q_red    (q_red),
    .q_green  (q_green),
    .q_blue   (q_blue),
    .res      (dres),
    .busy     (pipe_busy)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      npc_pkg::ST_IDLE: begin
        if (start) state_next = npc_pkg::ST_SCAN;
      end
      npc_pkg::ST_SCAN: begin
        if (scan_addr == LAST_ADDR) state_next = npc_pkg::ST_DRAIN;
      end
      npc_pkg::ST_DRAIN: begin
        if (load) state_next = npc_pkg::ST_IDLE;
      end
      default: state_next = npc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    items.ready = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    case (state)
      npc_pkg::ST_IDLE:  items.ready = 1'b1;
      npc_pkg::ST_SCAN:  issue = 1'b1;
      npc_pkg::ST_DRAIN: load = !rd_valid && !pipe_busy && (!out_valid || results.ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npc_pkg::ST_IDLE;
      gain      <= npc_pkg::UNITY_GAIN;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg.valid && cfg.ready) begin
        gain <= cfg.data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= npc_pkg::IDX_W'(scan_addr);
    if (start) begin
      q_red     <= items.red;
      q_green   <= items.green;
      q_blue    <= items.blue;
      q_skip    <= items.skip_zero;
      scan_addr <= items.skip_zero ? ADDR_W'(1) : '0;
      best      <= '0;
      best_dist <= npc_pkg::INIT_BEST_DIST;
    end else begin
      if (issue && scan_addr != LAST_ADDR) begin
        scan_addr <= scan_addr + ADDR_W'(1);
      end
      if (dres.valid && (npc_pkg::BEST_W'(dres.distance) < best_dist)) begin
        best      <= dres.idx;
        best_dist <= npc_pkg::BEST_W'(dres.distance);
      end
    end
    if (load) begin
      out_index <= best;
    end
  end

  assign cfg.ready             = 1'b1;
  assign results.valid         = out_valid;
  assign results.nearest_index = out_index;

  a_skip_never_zero: assert property (@(posedge clk) disable iff (rst)
    load && q_skip |-> best != '0)
    else $error("entry 0 reported although skipped");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == npc_pkg::ST_SCAN |-> scan_addr <= LAST_ADDR)
    else $error("scan address beyond palette");

  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == npc_pkg::ST_SCAN)
    else $error("palette read outside a scan");

  a_dist_in_query: assert property (@(posedge clk) disable iff (rst)
    dres.valid |-> state == npc_pkg::ST_SCAN || state == npc_pkg::ST_DRAIN)
    else $error("distance arrived outside a query");

endmodule

`default_nettype wire
